FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/bda_pkg.sv
package bda_pkg;

   localparam int NUM_BUTTONS = 3;
   localparam int MAX_RESULTS = 3;
   localparam int ADDR_W      = 5;

   localparam logic [1:0] EV_PRESSED  = 2'd0;
   localparam logic [1:0] EV_RELEASED = 2'd1;
   localparam logic [1:0] EV_LONG     = 2'd2;

   localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
   localparam logic [2:0] REG_LONG_DELAY  = 3'd1;
   localparam logic [2:0] REG_SHORT_DELAY = 3'd2;
   localparam logic [2:0] REG_FIXED_RATE  = 3'd3;
   localparam logic [2:0] REG_INVERT      = 3'd4;

   localparam int LONG_DELAY_DEFAULT = 1000;

   localparam logic [15:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [15:0] LONG_DELAY_RESET  = 16'(LONG_DELAY_DEFAULT);
   localparam logic [15:0] SHORT_DELAY_RESET = 16'(LONG_DELAY_DEFAULT / 8);
   localparam logic [15:0] PERIOD_RESET      = 16'(LONG_DELAY_DEFAULT);
   localparam int          FIXED_RATE_RESET  = 1;
   localparam int          INVERT_RESET      = 7;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] long_delay;
      logic [15:0] short_delay;
   } timing_cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
   } lane_ev_type;

endpackage

FILE: src/bda_lane.sv
module bda_lane
   import bda_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  logic           raw,
   input  logic           invert,
   input  logic           fixed_rate,
   input  timing_cfg_type cfg,
   output lane_ev_type    lane_ev
);

   logic        prev_ff, prev_in;
   logic [15:0] since_ff, since_in;
   logic        run_ff, run_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] period_ff, period_in;
   logic        long_ff, long_in;

   logic [15:0] since_inc;
   logic [15:0] elapsed_inc;
   logic        accepted;

   always_comb begin
      since_inc   = (since_ff == 16'hFFFF) ? since_ff : since_ff + 16'd1;
      elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
      accepted    = (raw != prev_ff) && (since_inc >= cfg.debounce_ticks);

      prev_in       = raw;
      since_in      = since_inc;
      run_in        = run_ff;
      elapsed_in    = elapsed_ff;
      period_in     = period_ff;
      long_in       = long_ff;
      lane_ev.valid = 1'b0;
      lane_ev.kind  = EV_PRESSED;

      if (accepted) begin
         since_in = 16'd0;
         if (raw ^ invert) begin
            long_in       = 1'b0;
            lane_ev.valid = 1'b1;
            lane_ev.kind  = EV_PRESSED;
            period_in     = cfg.long_delay;
            elapsed_in    = 16'd0;
            run_in        = 1'b1;
         end else begin
            run_in        = 1'b0;
            lane_ev.valid = !long_ff;
            lane_ev.kind  = EV_RELEASED;
         end
      end else if (run_ff) begin
         elapsed_in = elapsed_inc;
         if (elapsed_inc >= period_ff) begin
            long_in       = 1'b1;
            lane_ev.valid = 1'b1;
            lane_ev.kind  = EV_LONG;
            if (period_ff > cfg.short_delay) begin
               period_in = fixed_rate ? (cfg.long_delay >> 1) : (period_ff >> 1);
            end
            elapsed_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b0;
         since_ff   <= 16'd0;
         run_ff     <= 1'b0;
         elapsed_ff <= 16'd0;
         period_ff  <= PERIOD_RESET;
         long_ff    <= 1'b0;
      end else if (enable) begin
         prev_ff    <= prev_in;
         since_ff   <= since_in;
         run_ff     <= run_in;
         elapsed_ff <= elapsed_in;
         period_ff  <= period_in;
         long_ff    <= long_in;
      end
   end

endmodule

FILE: src/bda_merge.sv
module bda_merge
   import bda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  lane_ev_type lane_evs [NUM_BUTTONS],
   output logic        room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [1:0]  rsp_button_index,
   output logic        rsp_last_event
);

   logic [NUM_BUTTONS-1:0] pend_ff, pend_in;
   logic [1:0]             kind_ff [NUM_BUTTONS];
   logic                   valid_ff, valid_in;
   logic [1:0]             out_kind_ff, out_index_ff;
   logic                   out_last_ff;

   logic [NUM_BUTTONS-1:0] capped;
   logic [3:0]             taken;
   logic [NUM_BUTTONS-1:0] sel_oh;
   logic [NUM_BUTTONS-1:0] pend_rest;
   logic [1:0]             sel_kind;
   logic [1:0]             sel_index;
   logic                   out_free;
   logic                   unload;

   always_comb begin
      capped = '0;
      taken  = 4'd0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (lane_evs[i].valid && (taken < 4'(MAX_RESULTS))) begin
            capped[i] = 1'b1;
            taken     = taken + 4'd1;
         end
      end
   end

   always_comb begin
      sel_oh    = '0;
      sel_kind  = EV_PRESSED;
      sel_index = 2'd0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel_oh    = NUM_BUTTONS'(1) << i;
            sel_kind  = kind_ff[i];
            sel_index = 2'(i);
         end
      end
      pend_rest = pend_ff & ~sel_oh;
      out_free  = !valid_ff || !rsp_stall;
      unload    = out_free && (pend_ff != '0);
      room      = unload ? (pend_rest == '0) : (pend_ff == '0);
      pend_in   = load ? capped : (unload ? pend_rest : pend_ff);
      valid_in  = out_free ? (pend_ff != '0) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            kind_ff[i] <= lane_evs[i].kind;
         end
      end
      if (unload) begin
         out_kind_ff  <= sel_kind;
         out_index_ff <= sel_index;
         out_last_ff  <= (pend_rest == '0);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_button_index = out_index_ff;
   assign rsp_last_event   = out_last_ff;

endmodule

FILE: src/button_debounce_autorepeat.sv
// An accepted tick's events are held in the pending set, then moved into the output register.
// A tick yields at most three events; the single output register moves one event beat per
// cycle while rsp_stall does not hold it, and a new tick is taken as the last event of the
// previous one leaves the pending set, or while that set is empty.
// Reset: synchronous; registers return to their defaults and all button state clears.
`include "assert_macros.svh"

module button_debounce_autorepeat
   import bda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [NUM_BUTTONS-1:0] req_pin_levels,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_event_kind,
   output logic [1:0]             rsp_button_index,
   output logic                   rsp_last_event,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_W-1:0]      paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [15:0]            debounce_ff;
   logic [15:0]            long_delay_ff;
   logic [15:0]            short_delay_ff;
   logic [NUM_BUTTONS-1:0] fixed_rate_ff;
   logic [NUM_BUTTONS-1:0] invert_ff;

   timing_cfg_type cfg;
   lane_ev_type    lane_evs [NUM_BUTTONS];
   logic           room;
   logic           accept;
   logic [2:0]     reg_index;
   logic           csr_write;
   logic           rsp_more;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         long_delay_ff  <= LONG_DELAY_RESET;
         short_delay_ff <= SHORT_DELAY_RESET;
         fixed_rate_ff  <= NUM_BUTTONS'(FIXED_RATE_RESET);
         invert_ff      <= NUM_BUTTONS'(INVERT_RESET);
      end else if (csr_write) begin
         unique case (reg_index)
            REG_DEBOUNCE:    debounce_ff    <= pwdata[15:0];
            REG_LONG_DELAY:  long_delay_ff  <= pwdata[15:0];
            REG_SHORT_DELAY: short_delay_ff <= pwdata[15:0];
            REG_FIXED_RATE:  fixed_rate_ff  <= pwdata[NUM_BUTTONS-1:0];
            REG_INVERT:      invert_ff      <= pwdata[NUM_BUTTONS-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE:    prdata = 32'(debounce_ff);
         REG_LONG_DELAY:  prdata = 32'(long_delay_ff);
         REG_SHORT_DELAY: prdata = 32'(short_delay_ff);
         REG_FIXED_RATE:  prdata = 32'(fixed_rate_ff);
         REG_INVERT:      prdata = 32'(invert_ff);
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg.debounce_ticks = debounce_ff;
   assign cfg.long_delay     = long_delay_ff;
   assign cfg.short_delay    = short_delay_ff;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      bda_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .enable     (accept),
         .raw        (req_pin_levels[g]),
         .invert     (invert_ff[g]),
         .fixed_rate (fixed_rate_ff[g]),
         .cfg        (cfg),
         .lane_ev    (lane_evs[g])
      );
   end

   bda_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .lane_evs         (lane_evs),
      .room             (room),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_button_index (rsp_button_index),
      .rsp_last_event   (rsp_last_event)
   );

   assign rsp_more = rsp_valid && !rsp_stall && !rsp_last_event;

   // Events of one tick follow each other without a gap.
   `ASSERT_NEXT(a_tick_events_contiguous, clock, reset, rsp_valid && !rsp_last_event, rsp_valid)
   `ASSERT_IMPLY(a_kind_defined, clock, reset, rsp_valid, rsp_event_kind != EV_LONG + 2'd1)
   // Within one tick the events come out in rising button order.
   `ASSERT_NEXT(a_button_order, clock, reset, rsp_more, rsp_button_index > $past(rsp_button_index))

endmodule

FILE: tb/bda_event_check.sv
module bda_event_check
   import bda_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [2:0]        req_pin_levels,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_event_kind,
   input  logic [1:0]        rsp_button_index,
   input  logic              rsp_last_event,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output int                fail_count,
   output int                pending_count,
   output int                event_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUTTONS = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] button;
      logic       last;
   } event_beat_type;

   event_beat_type expected_events[$];

   logic [15:0]        debounce_ticks;
   logic [15:0]        long_delay;
   logic [15:0]        short_delay;
   logic [2:0]         fixed_rate;
   logic [2:0]         invert;
   logic [BUTTONS-1:0] pin_seen;
   logic [BUTTONS-1:0] timer_on;
   logic [BUTTONS-1:0] long_seen;
   logic [15:0]        since_edge   [BUTTONS];
   logic [15:0]        timer_count  [BUTTONS];
   logic [15:0]        timer_period [BUTTONS];

   function automatic void clear_state();
      debounce_ticks = DEBOUNCE_RESET;
      long_delay     = LONG_DELAY_RESET;
      short_delay    = SHORT_DELAY_RESET;
      fixed_rate     = 3'(FIXED_RATE_RESET);
      invert         = 3'(INVERT_RESET);
      pin_seen       = '0;
      timer_on       = '0;
      long_seen      = '0;
      for (int i = 0; i < BUTTONS; i++) begin
         since_edge[i]   = '0;
         timer_count[i]  = '0;
         timer_period[i] = PERIOD_RESET;
      end
   endfunction

   task automatic predict_tick(input logic [2:0] pins);
      event_beat_type found [BUTTONS];
      event_beat_type beat;
      int             n;
      int             kept;
      logic           took;
      n = 0;
      for (int i = 0; i < BUTTONS; i++) begin
         took = 1'b0;
         if (since_edge[i] != 16'hFFFF) since_edge[i]++;
         if (pins[i] != pin_seen[i]) begin
            pin_seen[i] = pins[i];
            if (since_edge[i] >= debounce_ticks) begin
               took = 1'b1;
               since_edge[i] = '0;
               if (pins[i] ^ invert[i]) begin
                  long_seen[i]    = 1'b0;
                  found[n]        = '{kind: EV_PRESSED, button: 2'(i), last: 1'b0};
                  n++;
                  timer_period[i] = long_delay;
                  timer_count[i]  = '0;
                  timer_on[i]     = 1'b1;
               end else begin
                  timer_on[i] = 1'b0;
                  if (!long_seen[i]) begin
                     found[n] = '{kind: EV_RELEASED, button: 2'(i), last: 1'b0};
                     n++;
                  end
               end
            end
         end
         if (!took && timer_on[i]) begin
            if (timer_count[i] != 16'hFFFF) timer_count[i]++;
            if (timer_count[i] >= timer_period[i]) begin
               long_seen[i] = 1'b1;
               found[n]     = '{kind: EV_LONG, button: 2'(i), last: 1'b0};
               n++;
               if (timer_period[i] > short_delay) begin
                  timer_period[i] = fixed_rate[i] ? (long_delay >> 1)
                                                  : (timer_period[i] >> 1);
               end
               timer_count[i] = '0;
            end
         end
      end
      kept = (n > MAX_RESULTS) ? MAX_RESULTS : n;
      for (int k = 0; k < kept; k++) begin
         beat      = found[k];
         beat.last = (k == kept - 1);
         expected_events.push_back(beat);
      end
      event_count += kept;
   endtask

   always @(posedge clock) begin
      event_beat_type want;
      if (reset) begin
         clear_state();
         expected_events.delete();
         fail_count  = 0;
         event_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: unexpected beat kind %0d button %0d last %0d", $time,
                           rsp_event_kind, rsp_button_index, rsp_last_event);
               end
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.kind || rsp_button_index !== want.button ||
                   rsp_last_event !== want.last) begin
                  if (fail_count < 10) begin
                     $display("%0t: expected kind %0d button %0d last %0d, got %0d %0d %0d",
                              $time, want.kind, want.button, want.last,
                              rsp_event_kind, rsp_button_index, rsp_last_event);
                  end
                  fail_count++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_DEBOUNCE:    debounce_ticks = pwdata[15:0];
               REG_LONG_DELAY:  long_delay     = pwdata[15:0];
               REG_SHORT_DELAY: short_delay    = pwdata[15:0];
               REG_FIXED_RATE:  fixed_rate     = pwdata[2:0];
               REG_INVERT:      invert         = pwdata[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_tick(req_pin_levels);
      end
      pending_count = expected_events.size();
   end

endmodule

FILE: tb/button_debounce_autorepeat_test.sv
module button_debounce_autorepeat_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bda_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_pin_levels;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_event_kind;
   logic [1:0]        rsp_button_index;
   logic              rsp_last_event;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   int                fail_count;
   int                pending_count;
   int                event_count;

   logic [2:0]        pins_now;
   logic [2:0]        invert_now;
   int                items_sent;
   int                burst_left;
   bit                no_gaps;
   int                choke_requests;

   button_debounce_autorepeat DUT (.*);

   bda_event_check u_event_check (.*);

   always #4 clock = ~clock;

   initial begin
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

   // The receiver stalls on a pattern of its own and, on request, holds off for a long stretch.
   initial begin
      int mode;
      int mode_left;
      int choke_served;
      mode         = 0;
      mode_left    = 0;
      choke_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (choke_requests != choke_served) begin
            choke_served = choke_requests;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic send_tick(input logic [2:0] pins);
      int gap;
      if (!no_gaps && burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid      <= 1'b1;
      req_pin_levels <= pins;
      pins_now = pins;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic random_tick();
      logic [2:0] pins;
      int         roll;
      int         idx;
      pins = pins_now;
      roll = $urandom_range(0, 99);
      idx  = $urandom_range(0, 2);
      if (roll < 55) begin
      end else if (roll < 85) begin
         pins[idx] = ~pins[idx];
      end else if (roll < 95) begin
         pins = 3'($urandom_range(0, 7));
      end else begin
         pins = ~pins;
      end
      send_tick(pins);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      logic [31:0] junk;
      junk = $urandom();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= (idx == REG_FIXED_RATE || idx == REG_INVERT) ? {junk[31:3], value[2:0]}
                                                               : {junk[31:16], value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [15:0] debounce, input logic [15:0] long_ticks,
                                input logic [15:0] short_ticks, input logic [2:0] fixed_mask,
                                input logic [2:0] invert_mask);
      go_idle();
      wait_drained();
      write_reg(REG_DEBOUNCE, debounce);
      write_reg(REG_LONG_DELAY, long_ticks);
      write_reg(REG_SHORT_DELAY, short_ticks);
      write_reg(REG_FIXED_RATE, 16'(fixed_mask));
      write_reg(REG_INVERT, 16'(invert_mask));
      invert_now = invert_mask;
   endtask

   initial begin
      int phase;
      int phase_items;
      int pause_at;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_pin_levels <= 3'b000;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      pins_now       = 3'b000;
      invert_now     = 3'(INVERT_RESET);
      items_sent     = 0;
      burst_left     = 0;
      no_gaps        = 1'b0;
      choke_requests = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Simultaneous presses, timers firing alongside edges, and three beats from one tick.
      apply_setting(16'd0, 16'd3, 16'd1, 3'b010, 3'b100);
      send_tick(3'b011);
      send_tick(3'b111);
      send_tick(3'b111);
      send_tick(3'b111);
      send_tick(3'b111);
      send_tick(3'b011);
      send_tick(3'b010);
      send_tick(3'b000);
      send_tick(3'b000);
      send_tick(3'b000);
      send_tick(3'b100);

      // Bounces inside the debounce window, then a press accepted while already pressed.
      go_idle();
      wait_drained();
      write_reg(REG_DEBOUNCE, 16'd4);
      send_tick(3'b101);
      send_tick(3'b100);
      send_tick(3'b101);
      send_tick(3'b100);
      send_tick(3'b100);
      send_tick(3'b101);
      send_tick(3'b101);
      send_tick(3'b001);
      send_tick(3'b000);

      phase = 0;
      while (items_sent < 170 && phase < 40) begin
         case (phase)
            0:       apply_setting(16'd0, 16'd1, 16'd1, 3'b000, 3'b000);
            1:       apply_setting(16'd1, 16'd2, 16'hFFFF, 3'b111, 3'b111);
            2:       apply_setting(16'd0, 16'd1, 16'd1, 3'b111, 3'b010);
            3:       apply_setting(16'd3, 16'd24, 16'd2, 3'b101, 3'b011);
            default: apply_setting(16'($urandom_range(0, 6)),
                                   ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                               : 16'($urandom_range(1, 24)),
                                   ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                               : 16'($urandom_range(1, 12)),
                                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
         endcase
         no_gaps = (phase == 2);
         if (phase == 2) choke_requests <= choke_requests + 1;
         phase_items = $urandom_range(20, 50);
         pause_at    = $urandom_range(0, 2 * phase_items);
         for (int k = 0; k < phase_items; k++) begin
            if (k == pause_at) begin
               go_idle();
               wait_drained();
            end
            random_tick();
         end
         no_gaps = 1'b0;
         phase++;
      end

      // Release every button, then offer edges that the widest debounce window rejects.
      go_idle();
      wait_drained();
      write_reg(REG_DEBOUNCE, 16'd0);
      send_tick(~invert_now);
      send_tick(invert_now);
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, invert_now);
      no_gaps = 1'b1;
      repeat (4) send_tick(invert_now);
      send_tick(invert_now ^ 3'b001);
      repeat (4) send_tick(invert_now ^ 3'b001);
      no_gaps = 1'b0;

      go_idle();
      wait_drained();
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/bda_pkg.sv
src/bda_lane.sv
src/bda_merge.sv
src/button_debounce_autorepeat.sv
tb/bda_event_check.sv
tb/button_debounce_autorepeat_test.sv
